// ----- rtl/core/euclidean_dda_line_stepper_top_defines.svh -----
// assertion macros shared by the line stepper rtl
`ifndef EUCLIDEAN_DDA_LINE_STEPPER_TOP_DEFINES_SVH
`define EUCLIDEAN_DDA_LINE_STEPPER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define EDLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("edls assertion failed");
// next-cycle implication, checked out of reset
`define EDLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("edls assertion failed");
`else
`define EDLS_ASSERT_IMP(lbl, ante, cons)
`define EDLS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/edls_pkg.sv -----
// shared types and constants of the line stepper
`timescale 1ns / 1ps
package edls_pkg;

    // command codes carried in the request tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // clip registers
    localparam int CLIP_W = 13;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 13'd1024;

    // register select taken from paddr[2]
    localparam logic REG_CLIP_WIDTH  = 1'b0;
    localparam logic REG_CLIP_HEIGHT = 1'b1;

    // load engine sequencer, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQX   = 9'b000000010,
        ST_SQY   = 9'b000000100,
        ST_SUM   = 9'b000001000,
        ST_LSQRT = 9'b000010000,
        ST_DINIT = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_QSQRT = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_eng_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;

endpackage

// ----- rtl/core/edls_load_engine.sv -----
// load engine: squared length from one squarer, then pixel count and unit steps on one shared subtractor
`timescale 1ns / 1ps
module edls_load_engine import edls_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic        [COORD_BITS-1:0]   i_start_x,
    input  logic        [COORD_BITS-1:0]   i_start_y,
    input  logic        [COORD_BITS-1:0]   i_end_x,
    input  logic        [COORD_BITS-1:0]   i_end_y,
    output t_eng_status                    o_status,
    output logic        [COORD_BITS:0]     o_count,
    output logic signed [FRAC_BITS+1:0]    o_step_x,
    output logic signed [FRAC_BITS+1:0]    o_step_y
);

    localparam int C       = COORD_BITS;
    localparam int F       = FRAC_BITS;
    localparam int SQ_W    = 2 * C;
    localparam int L2_W    = 2 * C + 1;
    localparam int Q_W     = 2 * F + 1;
    localparam int OP_MAX  = (Q_W > L2_W) ? Q_W : L2_W;
    localparam int SR_W    = ((OP_MAX + 1) / 2) * 2;
    localparam int SR_H    = SR_W / 2;
    localparam int U_W     = (L2_W + 1 > SR_H + 2) ? L2_W + 1 : SR_H + 2;
    localparam int CNT_MAX = (2 * F > SR_H) ? 2 * F : SR_H;
    localparam int CNT_W   = $clog2(CNT_MAX);

    t_eng_state r_state, n_state;

    logic        [C-1:0]     r_mx, r_my;
    logic                    r_negx, r_negy;
    logic        [SQ_W-1:0]  r_sqx, r_sqy;
    logic        [L2_W-1:0]  r_l2;
    logic        [L2_W-1:0]  r_rem;
    logic        [Q_W-1:0]   r_quo;
    logic        [SR_W-1:0]  r_sr_op;
    logic        [SR_H+1:0]  r_sr_rem;
    logic        [SR_H-1:0]  r_sr_root;
    logic        [CNT_W-1:0] r_cnt;
    logic                    r_axis;
    logic        [C:0]       r_count;
    logic signed [F+1:0]     r_step_x, r_step_y;

    // start deltas
    logic signed [C:0] dx, dy;
    logic        [C-1:0] abs_dx, abs_dy;

    always_comb begin
        dx = $signed({i_end_x[C-1], i_end_x}) - $signed({i_start_x[C-1], i_start_x});
        dy = $signed({i_end_y[C-1], i_end_y}) - $signed({i_start_y[C-1], i_start_y});
        abs_dx = dx[C] ? C'(-dx) : C'(dx);
        abs_dy = dy[C] ? C'(-dy) : C'(dy);
    end

    // one squarer, used for x then y
    logic [C-1:0]    mul_in;
    logic [SQ_W-1:0] mul_out;
    logic [L2_W-1:0] sum;
    logic [SQ_W-1:0] num;

    assign mul_in  = (r_state == ST_SQX) ? r_mx : r_my;
    assign mul_out = SQ_W'(mul_in) * SQ_W'(mul_in);
    assign sum     = L2_W'(r_sqx) + L2_W'(r_sqy);
    assign num     = r_axis ? r_sqy : r_sqx;

    // square root digit step operands
    logic [SR_H+1:0] sr_rem_sh, sr_trial;
    assign sr_rem_sh = {r_sr_rem[SR_H-1:0], r_sr_op[SR_W-1 -: 2]};
    assign sr_trial  = {r_sr_root, 2'b01};

    // shared compare and subtract
    logic [U_W-1:0] u_a, u_b, u_diff;
    logic           u_ge;

    always_comb begin
        case (r_state)
            ST_DINIT: begin
                u_a = U_W'(num);
                u_b = U_W'(r_l2);
            end
            ST_DIV: begin
                u_a = U_W'({r_rem, 1'b0});
                u_b = U_W'(r_l2);
            end
            default: begin
                u_a = U_W'(sr_rem_sh);
                u_b = U_W'(sr_trial);
            end
        endcase
        {u_ge, u_diff} = {1'b1, u_a} - {1'b0, u_b};
    end

    // results of one digit step
    logic [SR_H+1:0] sr_rem_nx;
    logic [SR_H-1:0] sr_root_nx;
    logic [Q_W-1:0]  quo_nx;
    logic            sr_last, div_last;
    logic [F:0]      step_mag;
    logic signed [F+1:0] step_val;
    logic            step_neg;

    always_comb begin
        sr_rem_nx  = u_ge ? u_diff[SR_H+1:0] : sr_rem_sh;
        sr_root_nx = {r_sr_root[SR_H-2:0], u_ge};
        quo_nx     = {r_quo[Q_W-2:0], u_ge};
        sr_last    = (r_cnt == CNT_W'(SR_H - 1));
        div_last   = (r_cnt == CNT_W'(2 * F - 1));
        step_mag   = sr_root_nx[F:0];
        step_neg   = r_axis ? r_negy : r_negx;
        step_val   = step_neg ? -$signed((F+2)'(step_mag)) : $signed((F+2)'(step_mag));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_SQX;
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = ST_SUM;
            ST_SUM:   n_state = (sum == '0) ? ST_DONE : ST_LSQRT;
            ST_LSQRT: if (sr_last) n_state = ST_DINIT;
            ST_DINIT: n_state = ST_DIV;
            ST_DIV:   if (div_last) n_state = ST_QSQRT;
            ST_QSQRT: if (sr_last) n_state = r_axis ? ST_DONE : ST_DINIT;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_mx   <= abs_dx;
                    r_my   <= abs_dy;
                    r_negx <= dx[C];
                    r_negy <= dy[C];
                end
            end
            ST_SQX: r_sqx <= mul_out;
            ST_SQY: r_sqy <= mul_out;
            ST_SUM: begin
                r_l2      <= sum;
                r_sr_op   <= SR_W'(sum);
                r_sr_rem  <= '0;
                r_sr_root <= '0;
                r_cnt     <= '0;
                r_axis    <= 1'b0;
                if (sum == '0) begin
                    r_count  <= '0;
                    r_step_x <= '0;
                    r_step_y <= '0;
                end
            end
            ST_LSQRT: begin
                r_sr_rem  <= sr_rem_nx;
                r_sr_root <= sr_root_nx;
                r_sr_op   <= {r_sr_op[SR_W-3:0], 2'b00};
                r_cnt     <= sr_last ? '0 : r_cnt + 1'b1;
                // ceiling: round up when a remainder is left
                if (sr_last) begin
                    r_count <= (C+1)'(sr_root_nx) + (C+1)'(sr_rem_nx != '0);
                end
            end
            ST_DINIT: begin
                r_quo <= Q_W'(u_ge);
                r_rem <= u_ge ? u_diff[L2_W-1:0] : L2_W'(num);
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= u_ge ? u_diff[L2_W-1:0] : {r_rem[L2_W-2:0], 1'b0};
                r_quo <= quo_nx;
                r_cnt <= div_last ? '0 : r_cnt + 1'b1;
                if (div_last) begin
                    r_sr_op   <= SR_W'(quo_nx);
                    r_sr_rem  <= '0;
                    r_sr_root <= '0;
                end
            end
            ST_QSQRT: begin
                r_sr_rem  <= sr_rem_nx;
                r_sr_root <= sr_root_nx;
                r_sr_op   <= {r_sr_op[SR_W-3:0], 2'b00};
                r_cnt     <= sr_last ? '0 : r_cnt + 1'b1;
                if (sr_last) begin
                    if (r_axis) r_step_y <= step_val;
                    else        r_step_x <= step_val;
                    r_axis <= 1'b1;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.done = (r_state == ST_DONE);
    assign o_count       = r_count;
    assign o_step_x      = r_step_x;
    assign o_step_y      = r_step_y;

endmodule

// ----- rtl/core/euclidean_dda_line_stepper_top.sv -----
// top level of the euclidean dda line stepper
//
// channel   dir  handshake             contents
// s_axis    in   tvalid/tready         tuser=command, tdata=start_x,start_y,end_x,end_y,color
// m_axis    out  tvalid/tready/tlast   tdata=pixel_x,pixel_y,pixel_color, tuser=write_enable
// apb       in   psel/penable/pready   clip_width at 0x0, clip_height at 0x4
//
// a step request registers the next pixel; the pixel sits in the output register until taken
// a load request keeps the block busy while the shared subtractor runs the length root,
//   two divisions and two step roots
// reset is synchronous, active low; it clears the line and sets both clip sizes to 1024
// a stalled output register holds back further requests
`timescale 1ns / 1ps
`include "euclidean_dda_line_stepper_top_defines.svh"
module euclidean_dda_line_stepper_top import edls_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 13
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // request stream
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // start_x, start_y, end_x, end_y, color, zero pad
    input  logic [((4*COORD_BITS+32+7)/8)*8-1:0]         s_axis_tdata,
    // command
    input  logic                                         s_axis_tuser,
    // pixel stream
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [((2*COORD_BITS+32+7)/8)*8-1:0]         m_axis_tdata,
    // write_enable
    output logic                                         m_axis_tuser,
    output logic                                         m_axis_tlast,
    // register port
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [2:0]                                   paddr,
    input  logic [31:0]                                  pwdata,
    output logic [31:0]                                  prdata,
    output logic                                         pready
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int OUT_W = ((2 * C + 32 + 7) / 8) * 8;
    localparam int ACC_W = C + F + 1;
    localparam int CMP_W = (C + 1 > CLIP_W) ? C + 1 : CLIP_W;

    // request fields
    logic [C-1:0]  in_start_x, in_start_y, in_end_x, in_end_y;
    logic [31:0]   in_color;

    assign in_start_x = s_axis_tdata[C-1:0];
    assign in_start_y = s_axis_tdata[2*C-1:C];
    assign in_end_x   = s_axis_tdata[3*C-1:2*C];
    assign in_end_y   = s_axis_tdata[4*C-1:3*C];
    assign in_color   = s_axis_tdata[4*C+31:4*C];

    // clip registers
    logic [CLIP_W-1:0] r_clip_w, r_clip_h;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_w <= CLIP_RESET;
            r_clip_h <= CLIP_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_CLIP_WIDTH:  r_clip_w <= pwdata[CLIP_W-1:0];
                REG_CLIP_HEIGHT: r_clip_h <= pwdata[CLIP_W-1:0];
                default: ;
            endcase
        end
    end

    // reads of unaligned addresses return zero
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_CLIP_WIDTH:  prdata = 32'(r_clip_w);
                REG_CLIP_HEIGHT: prdata = 32'(r_clip_h);
                default:         prdata = '0;
            endcase
        end
    end

    // request handshake
    t_eng_status          eng_status;
    logic [C:0]           eng_count;
    logic signed [F+1:0]  eng_step_x, eng_step_y;
    logic                 r_out_valid;
    logic                 in_acc, load_acc, step_acc;

    assign s_axis_tready = !eng_status.busy && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_acc      = in_acc && (s_axis_tuser == CMD_LOAD);
    assign step_acc      = in_acc && (s_axis_tuser == CMD_STEP);

    // length and unit steps are worked out here by the load engine sequencer
    edls_load_engine #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (load_acc),
        .i_start_x (in_start_x),
        .i_start_y (in_start_y),
        .i_end_x   (in_end_x),
        .i_end_y   (in_end_y),
        .o_status  (eng_status),
        .o_count   (eng_count),
        .o_step_x  (eng_step_x),
        .o_step_y  (eng_step_y)
    );

    // line state
    logic signed [ACC_W-1:0] r_pos_x, r_pos_y;
    logic        [C:0]       r_pixels_left;
    logic        [31:0]      r_color;

    // truncate toward zero and clip test, per axis
    logic              neg_x, neg_y;
    logic [ACC_W-1:0]  mag_x, mag_y;
    logic [C:0]        ip_x, ip_y;
    logic [C-1:0]      px, py;
    logic              in_x, in_y;

    always_comb begin
        neg_x = r_pos_x[ACC_W-1];
        neg_y = r_pos_y[ACC_W-1];
        mag_x = neg_x ? ACC_W'(-r_pos_x) : ACC_W'(r_pos_x);
        mag_y = neg_y ? ACC_W'(-r_pos_y) : ACC_W'(r_pos_y);
        ip_x  = mag_x[ACC_W-1:F];
        ip_y  = mag_y[ACC_W-1:F];
        px    = neg_x ? C'(-ip_x) : C'(ip_x);
        py    = neg_y ? C'(-ip_y) : C'(ip_y);
        // a fraction below zero truncates to zero, which is still inside when the clip size is not zero
        in_x  = !(neg_x && ip_x != '0) && (CMP_W'(ip_x) < CMP_W'(r_clip_w));
        in_y  = !(neg_y && ip_y != '0) && (CMP_W'(ip_y) < CMP_W'(r_clip_h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_left <= '0;
        end else if (load_acc) begin
            r_pixels_left <= '0;
        end else if (eng_status.done) begin
            r_pixels_left <= eng_count;
        end else if (step_acc && r_pixels_left != '0) begin
            r_pixels_left <= r_pixels_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            r_pos_x <= $signed({in_start_x[C-1], in_start_x, {F{1'b0}}});
            r_pos_y <= $signed({in_start_y[C-1], in_start_y, {F{1'b0}}});
            r_color <= in_color;
        end else if (step_acc && r_pixels_left != '0) begin
            r_pos_x <= r_pos_x + ACC_W'(eng_step_x);
            r_pos_y <= r_pos_y + ACC_W'(eng_step_y);
        end
    end

    // output register
    logic [C-1:0]  r_out_x, r_out_y;
    logic [31:0]   r_out_color;
    logic          r_out_we, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_acc && r_pixels_left != '0) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_acc && r_pixels_left != '0) begin
            r_out_x     <= px;
            r_out_y     <= py;
            r_out_color <= r_color;
            r_out_we    <= in_x && in_y;
            r_out_last  <= (r_pixels_left == (C+1)'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_color, r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_we;
    assign m_axis_tlast  = r_out_last;

    `EDLS_ASSERT_IMP(a_busy_blocks_requests, eng_status.busy, !s_axis_tready)
    `EDLS_ASSERT_NXT(a_done_sets_count, eng_status.done, r_pixels_left == $past(eng_count))
    `EDLS_ASSERT_NXT(a_step_emits_pixel, step_acc && r_pixels_left != '0, r_out_valid)
    `EDLS_ASSERT_NXT(a_idle_step_quiet, step_acc && r_pixels_left == '0, r_pixels_left == '0)

endmodule

// ----- tb/tb_euclidean_dda_line_stepper_top.sv -----
// self-checking testbench of the euclidean dda line stepper, with its own pixel predictor
`timescale 1ns / 1ps
module tb_euclidean_dda_line_stepper_top;
    import edls_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_BITS  = 13;
    localparam int DIN_W       = ((4*COORD_BITS+32+7)/8)*8;
    localparam int DOUT_W      = ((2*COORD_BITS+32+7)/8)*8;
    localparam int SX_LSB      = 0;
    localparam int SY_LSB      = COORD_BITS;
    localparam int EX_LSB      = 2*COORD_BITS;
    localparam int EY_LSB      = 3*COORD_BITS;
    localparam int COLOR_LSB   = 4*COORD_BITS;
    localparam int PY_LSB      = COORD_BITS;
    localparam int PCOLOR_LSB  = 2*COORD_BITS;
    localparam int COORD_MIN   = -(1 << (COORD_BITS-1));
    localparam int COORD_MAX   = (1 << (COORD_BITS-1)) - 1;
    localparam longint FRAC_ONE = 64'sd1 << FRAC_BITS;
    localparam int LOAD_SETTLE = 200;   // outlasts the time a load keeps the block busy
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 130;
    localparam int MAX_REPORTS = 100;
    localparam logic [2:0] ADDR_CLIP_WIDTH  = {REG_CLIP_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_CLIP_HEIGHT = {REG_CLIP_HEIGHT, 2'b00};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic [31:0]                  color;
        logic                         we;
        logic                         last;
    } t_pixel;

    typedef struct packed {
        logic                         cmd;
        logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
        logic [31:0]                  color;
        logic                         pinned;
        t_pixel                       pin;
    } t_stim_row;

    localparam t_pixel NO_PIX = '0;
    localparam int DIR_ROWS = 25;

    // directed requests; pinned rows carry a pixel read straight off the line geometry
    t_stim_row dir_rows [0:DIR_ROWS-1] = '{
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b0, NO_PIX},                    // no line after reset
        '{CMD_LOAD, 0, 0, 3, 0, 32'hA5A5A5A5, 1'b0, NO_PIX},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{0, 0, 32'hA5A5A5A5, 1'b1, 1'b0}},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{1, 0, 32'hA5A5A5A5, 1'b1, 1'b0}},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{2, 0, 32'hA5A5A5A5, 1'b1, 1'b1}},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b0, NO_PIX},                    // line used up
        '{CMD_LOAD, 5, 5, 5, 5, 32'h5A5A5A5A, 1'b0, NO_PIX},             // zero length
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b0, NO_PIX},
        '{CMD_LOAD, -4096, -4096, 4095, 4095, 32'hFFFFFFFF, 1'b0, NO_PIX},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{-4096, -4096, 32'hFFFFFFFF, 1'b0, 1'b0}},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b0, NO_PIX},
        '{CMD_LOAD, 4095, 4095, -4096, -4096, 32'h0, 1'b0, NO_PIX},      // replaces a live line
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{4095, 4095, 32'h0, 1'b0, 1'b0}},
        '{CMD_LOAD, 1023, 1023, 1023, 0, 32'h12345678, 1'b0, NO_PIX},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{1023, 1023, 32'h12345678, 1'b1, 1'b0}},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b0, NO_PIX},
        '{CMD_LOAD, 0, -1, 0, 5, 32'h87654321, 1'b0, NO_PIX},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{0, -1, 32'h87654321, 1'b0, 1'b0}},
        '{CMD_LOAD, -1, 0, 4, 0, 32'h0F0F0F0F, 1'b0, NO_PIX},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{-1, 0, 32'h0F0F0F0F, 1'b0, 1'b0}},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b0, NO_PIX},
        '{CMD_LOAD, 0, 0, 1, 1, 32'hF0F0F0F0, 1'b0, NO_PIX},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b1, '{0, 0, 32'hF0F0F0F0, 1'b1, 1'b0}},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b0, NO_PIX},
        '{CMD_STEP, 0, 0, 0, 0, 32'h0, 1'b0, NO_PIX}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DIN_W-1:0]      s_axis_tdata = '0;
    logic                  s_axis_tuser = CMD_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DOUT_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // line state mirrored by the predictor
    longint                pos_x, pos_y, step_x, step_y;
    int unsigned           line_left;
    logic [31:0]           line_color;
    logic [12:0]           clip_w, clip_h;

    t_pixel                pending_pixels [$];
    int                    errors;
    int                    quiet_cycles;
    int                    tx_idle_pct;
    int                    rx_idle_pct;

    euclidean_dda_line_stepper_top #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) r = trial;
        end
        return r;
    endfunction

    // d / sqrt(l2) in fixed point, truncated toward zero
    function automatic longint unit_step(input longint d, input longint unsigned l2);
        longint unsigned sq;
        longint mag;
        sq = longint'(d * d);
        mag = longint'(root_floor((sq << (2*FRAC_BITS)) / l2));
        return (d < 0) ? -mag : mag;
    endfunction

    // applies one accepted request to the mirrored line; returns 1 when a pixel follows
    function automatic bit rasterize_request(input logic cmd, input logic [DIN_W-1:0] data,
                                             output t_pixel pix);
        longint sx, sy, dx, dy, px, py;
        longint unsigned l2, len;
        pix = '0;
        if (cmd == CMD_LOAD) begin
            sx = longint'($signed(data[SX_LSB +: COORD_BITS]));
            sy = longint'($signed(data[SY_LSB +: COORD_BITS]));
            dx = longint'($signed(data[EX_LSB +: COORD_BITS])) - sx;
            dy = longint'($signed(data[EY_LSB +: COORD_BITS])) - sy;
            line_color = data[COLOR_LSB +: 32];
            pos_x = sx * FRAC_ONE;
            pos_y = sy * FRAC_ONE;
            l2 = longint'(dx * dx + dy * dy);
            if (l2 == 0) begin
                step_x = 0;
                step_y = 0;
                line_left = 0;
            end else begin
                len = root_floor(l2);
                if (len * len < l2) len++;
                line_left = int'(len);
                step_x = unit_step(dx, l2);
                step_y = unit_step(dy, l2);
            end
            return 1'b0;
        end
        if (line_left == 0) return 1'b0;
        // signed division truncates toward zero
        px = pos_x / FRAC_ONE;
        py = pos_y / FRAC_ONE;
        pix.px = px[COORD_BITS-1:0];
        pix.py = py[COORD_BITS-1:0];
        pix.color = line_color;
        pix.we = (px >= 0) && (px < longint'(clip_w)) && (py >= 0) && (py < longint'(clip_h));
        pix.last = (line_left == 1);
        pos_x += step_x;
        pos_y += step_y;
        line_left--;
        return 1'b1;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // coordinates biased toward the clip window and its borders
    function automatic int pick_coord(input int clip);
        case ($urandom_range(3))
            0: return int'($urandom_range(2*COORD_MAX + 1)) + COORD_MIN;
            1, 2: return clamp_coord(int'($urandom_range(clip + 16)) - 8);
            default: begin
                case ($urandom_range(3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 0;
                    default: return clamp_coord(clip - 1);
                endcase
            end
        endcase
    endfunction

    task automatic issue(input logic cmd, input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                         input logic [31:0] color, input bit pinned, input t_pixel pin,
                         output bit produced);
        logic [DIN_W-1:0] data;
        t_pixel pix;
        data = '0;
        data[SX_LSB +: COORD_BITS] = sx;
        data[SY_LSB +: COORD_BITS] = sy;
        data[EX_LSB +: COORD_BITS] = ex;
        data[EY_LSB +: COORD_BITS] = ey;
        data[COLOR_LSB +: 32] = color;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        produced = rasterize_request(cmd, data, pix);
        if (produced) pending_pixels.push_back(pinned ? pin : pix);
    endtask

    task automatic issue_step(output bit produced);
        issue(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), $urandom, 1'b0, NO_PIX, produced);
    endtask

    // stop sending until every pixel owed has come out
    task automatic wait_for_pixels();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_CLIP_WIDTH) clip_w = value[12:0];
        else clip_h = value[12:0];
    endtask

    // mostly whole lines stepped to their end, with long lines cut short and stray requests
    task automatic run_random(input int quota);
        int done_items, kind, sx, sy, ex, ey, steps;
        bit produced;
        done_items = 0;
        while (done_items < quota) begin
            kind = $urandom_range(99);
            if (kind < 2) begin
                wait_for_pixels();
            end else if (kind < 72) begin
                sx = pick_coord(int'(clip_w));
                sy = pick_coord(int'(clip_h));
                ex = clamp_coord(sx + int'($urandom_range(48)) - 24);
                ey = clamp_coord(sy + int'($urandom_range(48)) - 24);
                issue(CMD_LOAD, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex),
                      COORD_BITS'(ey), $urandom, 1'b0, NO_PIX, produced);
                done_items++;
                steps = (line_left > 40) ? $urandom_range(1, 40)
                                         : int'(line_left) + $urandom_range(2);
                repeat (steps) begin
                    issue_step(produced);
                    done_items += produced;
                end
            end else if (kind < 87) begin
                issue(CMD_LOAD, COORD_BITS'(pick_coord(int'(clip_w))),
                      COORD_BITS'(pick_coord(int'(clip_h))),
                      COORD_BITS'(pick_coord(int'(clip_w))),
                      COORD_BITS'(pick_coord(int'(clip_h))), $urandom,
                      1'b0, NO_PIX, produced);
                done_items++;
                repeat ($urandom_range(1, 30)) begin
                    issue_step(produced);
                    done_items += produced;
                end
            end else if (kind < 93) begin
                issue_step(produced);
                done_items += produced;
            end else begin
                sx = pick_coord(int'(clip_w));
                sy = pick_coord(int'(clip_h));
                issue(CMD_LOAD, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(sx),
                      COORD_BITS'(sy), $urandom, 1'b0, NO_PIX, produced);
                done_items++;
                issue_step(produced);
            end
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // pixel checker
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel with none expected, x %0d y %0d", $time,
                         $signed(m_axis_tdata[0 +: COORD_BITS]),
                         $signed(m_axis_tdata[PY_LSB +: COORD_BITS]));
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.px, $signed(m_axis_tdata[0 +: COORD_BITS]));
                check_field("pixel_y", want.py, $signed(m_axis_tdata[PY_LSB +: COORD_BITS]));
                check_field("pixel_color", want.color, m_axis_tdata[PCOLOR_LSB +: 32]);
                check_field("write_enable", want.we, m_axis_tuser);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int widths [0:PHASES-1];
        int heights [0:PHASES-1];
        bit produced;
        widths = '{1024, 0, 4096, 32'hFFFF_E280, 4096, 0};
        heights = '{1024, 4096, 1, 32'hFFFF_E1E0, 4096, 0};
        widths[PHASES-1] = $urandom_range(1, 4096);
        heights[PHASES-1] = $urandom_range(1, 4096);
        pos_x = 0;
        pos_y = 0;
        step_x = 0;
        step_y = 0;
        line_left = 0;
        line_color = '0;
        clip_w = CLIP_RESET;
        clip_h = CLIP_RESET;
        errors = 0;
        quiet_cycles = 0;
        tx_idle_pct = 28;
        rx_idle_pct = 51;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            // both sides idle, then swapped, then neither
            case (p / 2)
                0: begin tx_idle_pct = 28; rx_idle_pct = 51; end
                1: begin tx_idle_pct = 51; rx_idle_pct = 28; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (p > 0) begin
                wait_for_pixels();
                repeat (LOAD_SETTLE) @(posedge i_clk);
                reg_write(ADDR_CLIP_WIDTH, widths[p]);
                reg_write(ADDR_CLIP_HEIGHT, heights[p]);
            end else begin
                for (int i = 0; i < DIR_ROWS; i++)
                    issue(dir_rows[i].cmd, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                          dir_rows[i].ey, dir_rows[i].color, dir_rows[i].pinned,
                          dir_rows[i].pin, produced);
            end
            run_random(PHASE_ITEMS);
        end

        wait_for_pixels();
        repeat (LOAD_SETTLE) @(posedge i_clk);
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
